[hdl/bcle_pkg.sv]
package bcle_pkg;

  localparam int unsigned ADC_W     = 12;
  localparam int unsigned MV_W      = 14;
  localparam int unsigned FULL_W    = 13;
  localparam int unsigned LVL_W     = 12;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // divider: quotient bits, remainder and divisor widths
  localparam int unsigned QUO_W     = 7;
  localparam int unsigned REM_W     = PERIOD_W + QUO_W;
  localparam int unsigned EL_PROD_W = TIME_W + PCT_W;

  localparam int unsigned SAMPLES_PER_GROUP_DEF = 8;
  localparam int unsigned ADC_BITS_DEF          = 12;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  localparam logic [MV_W-1:0]     HELD_RESET_MV      = 14'd4500;
  localparam logic [PCT_W-1:0]    CHARGE_CAP_PERCENT = 7'd95;
  localparam logic [PCT_W-1:0]    FULL_PERCENT       = 7'd100;
  localparam logic [PCT_W-1:0]    FLOOR_PERCENT      = 7'd5;
  localparam logic [MV_W-1:0]     TOP_SEG_MV         = 14'd4100;
  localparam logic [MV_W-1:0]     TEN_SEG_HI_MV      = 14'd3700;
  localparam logic [PCT_W-1:0]    TOP_SEG_BASE       = 7'd90;
  localparam logic [PCT_W-1:0]    TEN_SEG_BASE       = 7'd10;
  localparam logic [PCT_W-1:0]    FIVE_SEG_BASE      = 7'd5;

  localparam logic [15:0] FS_RESET     = 16'd7200;
  localparam logic [15:0] FULL_RESET   = 16'd4200;
  localparam logic [15:0] TEN_RESET    = 16'd3650;
  localparam logic [15:0] FIVE_RESET   = 16'd3500;
  localparam logic [15:0] PERIOD_RESET = 16'd5400;

  localparam int unsigned NUM_SEG = 7;
  localparam logic [MV_W-1:0] SEG_LO [NUM_SEG] =
    '{14'd4050, 14'd3950, 14'd3900, 14'd3850, 14'd3800, 14'd3750, 14'd3700};
  localparam logic [MV_W-1:0] SEG_HI [NUM_SEG] =
    '{14'd4100, 14'd4050, 14'd3950, 14'd3900, 14'd3850, 14'd3800, 14'd3750};
  localparam logic [PCT_W-1:0] SEG_BASE [NUM_SEG] =
    '{7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_FULL_SCALE = 3'd0,
    CFG_FULL_VOLTAGE   = 3'd1,
    CFG_TEN_PERCENT    = 3'd2,
    CFG_FIVE_PERCENT   = 3'd3,
    CFG_CHARGE_PERIOD  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ADC_W-1:0]  adc_sample;
    logic              on_charger;
    logic              charge_full;
    logic [PCT_W-1:0]  stored_percent;
    logic [TIME_W-1:0] now_seconds;
    logic [TIME_W-1:0] charge_start_seconds;
    logic [PCT_W-1:0]  charge_start_percent;
  } in_word_t;

  typedef struct packed {
    logic [MV_W-1:0]  battery_mv;
    logic [PCT_W-1:0] charge_percent;
    logic             low_power_request;
    logic             save_percent;
  } out_word_t;

  typedef struct packed {
    logic [MV_W-1:0]     adc_full_scale_mv;
    logic [FULL_W-1:0]   full_voltage_mv;
    logic [LVL_W-1:0]    ten_percent_mv;
    logic [LVL_W-1:0]    five_percent_mv;
    logic [PERIOD_W-1:0] charge_period_s;
  } cfg_t;

  // one closed group, handed from front to back
  typedef struct packed {
    logic [ADC_W-1:0]  group_max;
    logic              on_charger;
    logic              charge_full;
    logic [PCT_W-1:0]  stored_percent;
    logic [TIME_W-1:0] elapsed_s;
    logic [PCT_W-1:0]  start_percent;
  } job_t;

endpackage

[hdl/bcle_front.sv]
module bcle_front
  import bcle_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
  parameter int unsigned ADC_BITS          = ADC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  localparam int unsigned CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_GROUP - 1);
  localparam int unsigned MASK_BITS = (ADC_BITS >= ADC_W) ? ADC_W : ADC_BITS;
  localparam logic [ADC_W-1:0] SMP_MASK = ADC_W'((64'd1 << MASK_BITS) - 64'd1);

  logic [CNT_W-1:0] sample_count;
  logic [ADC_W-1:0] running_max;
  logic [ADC_W-1:0] sample;
  logic [ADC_W-1:0] max_next;
  logic             accept;
  logic             last;

  assign accept   = push && !q_full;
  assign sample   = in_word.adc_sample & SMP_MASK;
  assign max_next = (sample > running_max) ? sample : running_max;
  assign last     = (sample_count == LAST_CNT);

  assign q_push = accept && last;
  always_comb begin
    q_job.group_max      = max_next;
    q_job.on_charger     = in_word.on_charger;
    q_job.charge_full    = in_word.charge_full;
    q_job.stored_percent = in_word.stored_percent;
    q_job.elapsed_s      = in_word.now_seconds - in_word.charge_start_seconds;
    q_job.start_percent  = in_word.charge_start_percent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_max  <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count <= '0;
        running_max  <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        running_max  <= max_next;
      end
    end
  end

endmodule

[hdl/bcle_queue.sv]
module bcle_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == DEPTH_CNT);
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hdl/bcle_back.sv]
module bcle_back
  import bcle_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  input  logic      res_pop,
  output logic      res_valid,
  output out_word_t res_word
);

  localparam int unsigned PROD_W = ADC_W + MV_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_HOLD, S_MAP, S_CHK, S_DIV, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PM_DIRECT, PM_CAP95, PM_STORED
  } pct_mode_t;

  state_t            state;
  pct_mode_t         pct_mode;
  job_t              job;
  logic [MV_W-1:0]   held_mv;
  logic [PROD_W-1:0] prod_mv;
  logic [EL_PROD_W-1:0] prod_el;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [2:0]        step;
  logic [PCT_W-1:0]  base;
  logic              low_power;
  logic              save;

  // discharge voltage after scaling, and the held value it leads to
  logic [MV_W-1:0]   mv;
  logic [MV_W-1:0]   held_next;
  // segment selection on the held voltage
  logic [PCT_W-1:0]  map_base;
  logic [MV_W-1:0]   map_diff;
  logic [REM_W-1:0]  map_num;
  logic [PERIOD_W-1:0] map_div;
  logic [2:0]        seg_sel;
  logic              seg_hit;
  logic [EL_PROD_W-1:0] cap_lim;
  logic [PCT_W:0]    pct_sum;
  logic [PCT_W-1:0]  pct_final;
  logic              div_ge;

  assign q_pop = (state == S_IDLE) && !q_empty;

  assign mv        = MV_W'(prod_mv >> ADC_BITS);
  assign held_next = (held_mv < MV_W'(cfg.ten_percent_mv))
                     ? ((mv < held_mv) ? mv : held_mv) : mv;

  always_comb begin
    seg_sel = 3'd0;
    seg_hit = 1'b0;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (held_mv >= SEG_LO[i]) begin
        seg_sel = 3'(i);
        seg_hit = 1'b1;
      end
    end
  end

  always_comb begin
    map_base = FLOOR_PERCENT;
    map_diff = '0;
    map_num  = '0;
    map_div  = PERIOD_W'(1);
    if (held_mv >= MV_W'(cfg.full_voltage_mv)) begin
      map_base = FULL_PERCENT;
    end else if (held_mv >= TOP_SEG_MV) begin
      map_base = TOP_SEG_BASE;
      map_diff = held_mv - TOP_SEG_MV;
      map_num  = REM_W'({map_diff, 3'b000}) + REM_W'({map_diff, 1'b0});
      map_div  = PERIOD_W'(MV_W'(cfg.full_voltage_mv) - TOP_SEG_MV);
    end else if (seg_hit) begin
      map_base = SEG_BASE[seg_sel];
      map_diff = held_mv - SEG_LO[seg_sel];
      map_num  = REM_W'({map_diff, 3'b000}) + REM_W'({map_diff, 1'b0});
      map_div  = PERIOD_W'(SEG_HI[seg_sel] - SEG_LO[seg_sel]);
    end else if (held_mv >= MV_W'(cfg.ten_percent_mv)) begin
      map_base = TEN_SEG_BASE;
      map_diff = held_mv - MV_W'(cfg.ten_percent_mv);
      map_num  = REM_W'({map_diff, 3'b000}) + REM_W'({map_diff, 1'b0});
      map_div  = PERIOD_W'(TEN_SEG_HI_MV - MV_W'(cfg.ten_percent_mv));
    end else if (held_mv >= MV_W'(cfg.five_percent_mv)) begin
      map_base = FIVE_SEG_BASE;
      map_diff = held_mv - MV_W'(cfg.five_percent_mv);
      map_num  = REM_W'({map_diff, 2'b00}) + REM_W'(map_diff);
      map_div  = PERIOD_W'(cfg.ten_percent_mv - cfg.five_percent_mv);
    end
  end

  // share above 95 iff elapsed*100 >= 96*period; zero period lands here too
  assign cap_lim = EL_PROD_W'({cfg.charge_period_s, 6'b0})
                 + EL_PROD_W'({cfg.charge_period_s, 5'b0});

  assign div_ge  = (rem >= dsh);
  assign pct_sum = {1'b0, base} + {1'b0, quo};

  always_comb begin
    case (pct_mode)
      PM_CAP95:  pct_final = (pct_sum > {1'b0, CHARGE_CAP_PERCENT})
                             ? CHARGE_CAP_PERCENT : pct_sum[PCT_W-1:0];
      PM_STORED: pct_final = (pct_sum > {1'b0, job.stored_percent})
                             ? job.stored_percent : pct_sum[PCT_W-1:0];
      default:   pct_final = pct_sum[PCT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      held_mv   <= HELD_RESET_MV;
      pct_mode  <= PM_DIRECT;
    end else begin
      // in S_FIN the slot is refilled below on a pop
      if (res_pop && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_mv <= PROD_W'(job.group_max) * PROD_W'(cfg.adc_full_scale_mv);
          prod_el <= EL_PROD_W'(job.elapsed_s) * EL_PROD_W'(100);
          quo     <= '0;
          if (!job.on_charger) begin
            save  <= 1'b0;
            state <= S_HOLD;
          end else if (job.charge_full) begin
            save      <= 1'b1;
            low_power <= 1'b0;
            held_mv   <= HELD_RESET_MV;
            base      <= FULL_PERCENT;
            pct_mode  <= PM_DIRECT;
            state     <= S_FIN;
          end else begin
            save      <= 1'b1;
            low_power <= 1'b0;
            state     <= S_CHK;
          end
        end
        S_HOLD: begin
          held_mv <= held_next;
          state   <= S_MAP;
        end
        S_MAP: begin
          low_power <= (held_mv < MV_W'(cfg.ten_percent_mv));
          base      <= map_base;
          pct_mode  <= PM_STORED;
          rem       <= map_num;
          dsh       <= {map_div, {QUO_W-1{1'b0}}, 1'b0} >> 1;
          step      <= '0;
          state     <= S_DIV;
        end
        S_CHK: begin
          if (prod_el >= cap_lim) begin
            base     <= CHARGE_CAP_PERCENT;
            pct_mode <= PM_DIRECT;
            state    <= S_FIN;
          end else begin
            base     <= job.start_percent;
            pct_mode <= PM_CAP95;
            rem      <= prod_el[REM_W-1:0];
            dsh      <= {cfg.charge_period_s, {QUO_W-1{1'b0}}, 1'b0} >> 1;
            step     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle, msb first
          if (div_ge) begin
            rem <= rem - dsh;
          end
          quo  <= {quo[QUO_W-2:0], div_ge};
          dsh  <= dsh >> 1;
          step <= step + 1'b1;
          if (step == 3'(QUO_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || res_pop) begin
            res_valid                  <= 1'b1;
            res_word.battery_mv        <= held_mv;
            res_word.charge_percent    <= pct_final;
            res_word.low_power_request <= low_power;
            res_word.save_percent      <= save;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/battery_charge_level_estimator_top.sv]
// channel  | handshake               | word
// ---------+-------------------------+-------------------------------------
// input    | push / full             | in_word  (in_word_t)
// result   | empty / pop             | out_word (out_word_t), one per group
// config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One sample per cycle while full is low; a group-closing sample queues a job.
// A job runs S_MUL, then S_FIN on a full charge, S_CHK when the charge share
// is capped, else S_CHK (charging) or S_HOLD and S_MAP (discharging) before the
// 7-step serial divider; the job queue lets the front take samples meanwhile.
// Synchronous reset clears counts, queue, result slot and restores registers.
// A result that is not popped holds the back end; full rises once the queue fills.
module battery_charge_level_estimator_top
  import bcle_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
  parameter int unsigned ADC_BITS          = ADC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_word_t             in_word,
  output logic                 empty,
  input  logic                 pop,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_push;
  job_t q_wr_job;
  job_t q_rd_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic res_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_full_scale_mv <= MV_W'(FS_RESET);
      cfg.full_voltage_mv   <= FULL_W'(FULL_RESET);
      cfg.ten_percent_mv    <= LVL_W'(TEN_RESET);
      cfg.five_percent_mv   <= LVL_W'(FIVE_RESET);
      cfg.charge_period_s   <= PERIOD_W'(PERIOD_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ADC_FULL_SCALE: cfg.adc_full_scale_mv <= cfg_data[MV_W-1:0];
        CFG_FULL_VOLTAGE:   cfg.full_voltage_mv   <= cfg_data[FULL_W-1:0];
        CFG_TEN_PERCENT:    cfg.ten_percent_mv    <= cfg_data[LVL_W-1:0];
        CFG_FIVE_PERCENT:   cfg.five_percent_mv   <= cfg_data[LVL_W-1:0];
        CFG_CHARGE_PERIOD:  cfg.charge_period_s   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  bcle_front #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .in_word(in_word),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(q_wr_job)
  );

  bcle_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(q_push),
    .wr_data(q_wr_job),
    .rd_en(q_pop),
    .rd_data(q_rd_job),
    .full(q_full),
    .empty(q_empty)
  );

  bcle_back #(
    .ADC_BITS(ADC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_empty(q_empty),
    .q_job(q_rd_job),
    .q_pop(q_pop),
    .res_pop(pop && res_valid),
    .res_valid(res_valid),
    .res_word(out_word)
  );

endmodule

[hdl/bcle_checker.sv]
module bcle_checker
  import bcle_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result word changed or vanished");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(out_word.save_percent && out_word.low_power_request))
    else $error("low power flagged while charging");

  a_full_resets_mv: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_word.save_percent && out_word.charge_percent == FULL_PERCENT)
    |-> (out_word.battery_mv == HELD_RESET_MV))
    else $error("full charge without held voltage reset");

endmodule

bind battery_charge_level_estimator_top bcle_checker u_bcle_checker (.*);

[sim/tb_battery_charge_level_estimator_top.sv]
`timescale 1ns / 100ps

module tb_battery_charge_level_estimator_top;
  import bcle_pkg::*;

  localparam int unsigned GROUP_LEN     = 8;
  localparam int unsigned HELD_START_MV = 4500;
  localparam int unsigned CHG_CAP       = 95;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned PHASE_GROUPS  = 23;

  // knee points of the discharge curve, top down
  localparam int unsigned KNEE_MV [8] = '{4100, 4050, 3950, 3900, 3850, 3800, 3750, 3700};
  localparam int unsigned KNEE_PCT [8] = '{90, 80, 70, 60, 50, 40, 30, 20};

  typedef struct packed {
    logic [ADC_W-1:0]  peak;
    logic              on_chg;
    logic              chg_full;
    logic [PCT_W-1:0]  stored;
    logic [TIME_W-1:0] now_s;
    logic [TIME_W-1:0] start_s;
    logic [PCT_W-1:0]  start_pct;
    logic              typed;
    out_word_t         want;
  } group_row_t;

  localparam int unsigned PLAN_LEN = 11;
  localparam group_row_t PLAN [PLAN_LEN] = '{
    '{12'd4095, 1'b0, 1'b0, 7'd100, 32'd0, 32'd0, 7'd0, 1'b1, '{14'd7198, 7'd100, 1'b0, 1'b0}},
    '{12'd0, 1'b1, 1'b1, 7'd0, 32'd0, 32'd0, 7'd0, 1'b1, '{14'd4500, 7'd100, 1'b0, 1'b1}},
    '{12'd0, 1'b0, 1'b0, 7'd100, 32'd0, 32'd0, 7'd0, 1'b1, '{14'd0, 7'd5, 1'b1, 1'b0}},
    // below the ten percent level the voltage only falls
    '{12'd4095, 1'b0, 1'b0, 7'd127, 32'd0, 32'd0, 7'd0, 1'b1, '{14'd0, 7'd5, 1'b1, 1'b0}},
    // elapsed wraps through zero, start percent over range
    '{12'd4095, 1'b1, 1'b0, 7'd0, 32'd5, 32'hFFFF_FFFB, 7'd127, 1'b1,
      '{14'd0, 7'd95, 1'b0, 1'b1}},
    '{12'd1234, 1'b1, 1'b0, 7'd0, 32'hFFFF_FFFF, 32'd0, 7'd0, 1'b1,
      '{14'd0, 7'd95, 1'b0, 1'b1}},
    '{12'd4095, 1'b1, 1'b1, 7'd0, 32'd0, 32'd0, 7'd0, 1'b1, '{14'd4500, 7'd100, 1'b0, 1'b1}},
    '{12'd2105, 1'b0, 1'b0, 7'd64, 32'd0, 32'd0, 7'd0, 1'b0, '0},
    '{12'd2076, 1'b0, 1'b0, 7'd127, 32'd0, 32'd0, 7'd0, 1'b0, '0},
    '{12'd4095, 1'b1, 1'b0, 7'd0, 32'd2700, 32'd0, 7'd10, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b0, 7'd0, 32'd0, 32'd0, 7'd0, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_word_t             in_word;
  logic                 empty;
  logic                 pop;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // predictor state
  cfg_t             lvl;
  int unsigned      grp_count;
  logic [ADC_W-1:0] grp_peak;
  int unsigned      held_mv;

  out_word_t pending_readings[$];
  int        errors;
  bit        final_run;
  bit        sender_quiet;
  int        stall_left;
  int        calm_left;

  battery_charge_level_estimator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned mv_to_percent(int unsigned v);
    int unsigned fv;
    int unsigned tv;
    int unsigned fiv;
    int i;
    fv  = lvl.full_voltage_mv;
    tv  = lvl.ten_percent_mv;
    fiv = lvl.five_percent_mv;
    if (v >= fv) return 100;
    if (v >= KNEE_MV[0]) return KNEE_PCT[0] + 10 * (v - KNEE_MV[0]) / (fv - KNEE_MV[0]);
    for (i = 1; i < 8; i++) begin
      if (v >= KNEE_MV[i])
        return KNEE_PCT[i] + 10 * (v - KNEE_MV[i]) / (KNEE_MV[i-1] - KNEE_MV[i]);
    end
    if (v >= tv) return 10 + 10 * (v - tv) / (KNEE_MV[7] - tv);
    if (v >= fiv) return 5 + 5 * (v - fiv) / (tv - fiv);
    return 5;
  endfunction

  task automatic estimate_charge(input in_word_t w, output bit closes, output out_word_t r);
    longint unsigned share;
    longint unsigned total;
    logic [TIME_W-1:0] el;
    int unsigned mv;
    int unsigned pct;
    closes = 1'b0;
    r = '0;
    if (w.adc_sample > grp_peak) grp_peak = w.adc_sample;
    grp_count++;
    if (grp_count < GROUP_LEN) return;
    closes = 1'b1;
    if (!w.on_charger) begin
      mv = 32'((64'(grp_peak) * lvl.adc_full_scale_mv) >> 12) & 32'h3FFF;
      if (held_mv < lvl.ten_percent_mv) begin
        if (mv < held_mv) held_mv = mv;
      end else begin
        held_mv = mv;
      end
      pct = mv_to_percent(held_mv);
      if (pct > w.stored_percent) pct = w.stored_percent;
      r.low_power_request = (held_mv < lvl.ten_percent_mv);
    end else begin
      r.save_percent = 1'b1;
      if (w.charge_full) begin
        held_mv = HELD_START_MV;
        pct = 100;
      end else begin
        el = w.now_seconds - w.charge_start_seconds;
        if (lvl.charge_period_s == '0) share = '1;
        else share = (64'(el) * 100) / lvl.charge_period_s;
        total = (share > CHG_CAP) ? CHG_CAP : share + w.charge_start_percent;
        pct = (total > CHG_CAP) ? CHG_CAP : int'(total);
      end
    end
    grp_count = 0;
    grp_peak = '0;
    r.battery_mv = MV_W'(held_mv);
    r.charge_percent = PCT_W'(pct);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w.adc_sample           = ADC_W'($urandom_range(4095, 0));
    w.on_charger           = 1'($urandom_range(1, 0));
    w.charge_full          = 1'($urandom_range(1, 0));
    w.stored_percent       = PCT_W'($urandom_range(127, 0));
    w.now_seconds          = $urandom;
    w.charge_start_seconds = $urandom;
    w.charge_start_percent = PCT_W'($urandom_range(127, 0));
    return w;
  endfunction

  // eight samples; the peak lands on a random slot, the last word closes the group
  task automatic put_group(input logic [ADC_W-1:0] peak, input in_word_t close_w,
                           input bit typed, input out_word_t want);
    in_word_t w;
    out_word_t r;
    bit closes;
    int pos;
    int k;
    pos = $urandom_range(GROUP_LEN - 1, 0);
    sender_quiet = ($urandom_range(3, 0) == 0);
    for (k = 0; k < GROUP_LEN; k++) begin
      w = (k == GROUP_LEN - 1) ? close_w : random_word();
      w.adc_sample = (k == pos) ? peak : ADC_W'($urandom_range(peak, 0));
      push <= 1'b1;
      in_word <= w;
      do @(posedge clk); while (full);
      estimate_charge(w, closes, r);
      if (closes) pending_readings.push_back(typed ? want : r);
      if (!final_run && !sender_quiet && $urandom_range(4, 0) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end
    end
  endtask

  task automatic random_group();
    in_word_t cw;
    logic [ADC_W-1:0] peak;
    int unsigned fs;
    int unsigned tv;
    int unsigned per;
    int unsigned el;
    cw = random_word();
    fs = lvl.adc_full_scale_mv;
    per = lvl.charge_period_s;
    if ($urandom_range(9, 0) == 0 || fs < 800) begin
      peak = ADC_W'($urandom_range(4095, 0));
    end else begin
      tv = $urandom_range(5100, 2900);
      tv = (tv * 4096 + fs - 1) / fs;
      peak = (tv > 4095) ? ADC_W'(4095) : ADC_W'(tv);
    end
    if ($urandom_range(9, 0) < 7) cw.stored_percent = 7'd100;
    cw.on_charger = ($urandom_range(99, 0) < 35);
    cw.charge_full = ($urandom_range(3, 0) == 0);
    if ($urandom_range(7, 0) != 0) begin
      el = (per == 0) ? $urandom : $urandom_range(per + per / 4, 0);
      cw.now_seconds = cw.charge_start_seconds + el;
      cw.charge_start_percent = PCT_W'($urandom_range(100, 0));
    end
    put_group(peak, cw, 1'b0, '0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ADC_FULL_SCALE: lvl.adc_full_scale_mv = data[MV_W-1:0];
      CFG_FULL_VOLTAGE:   lvl.full_voltage_mv   = data[FULL_W-1:0];
      CFG_TEN_PERCENT:    lvl.ten_percent_mv    = data[LVL_W-1:0];
      CFG_FIVE_PERCENT:   lvl.five_percent_mv   = data[LVL_W-1:0];
      CFG_CHARGE_PERIOD:  lvl.charge_period_s   = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(input logic [15:0] fs, input logic [15:0] fv,
                            input logic [15:0] tv, input logic [15:0] fiv,
                            input logic [15:0] per);
    write_reg(CFG_ADC_FULL_SCALE, fs);
    write_reg(CFG_FULL_VOLTAGE, fv);
    write_reg(CFG_TEN_PERCENT, tv);
    write_reg(CFG_FIVE_PERCENT, fiv);
    write_reg(CFG_CHARGE_PERIOD, per);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // result side: check every popped word, pop with random stall bursts
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && pop && !empty) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none got mv %0d pct %0d lp %0d save %0d",
                 $time, out_word.battery_mv, out_word.charge_percent,
                 out_word.low_power_request, out_word.save_percent);
      end else begin
        exp_w = pending_readings.pop_front();
        cmp_field("battery_mv", exp_w.battery_mv, out_word.battery_mv);
        cmp_field("charge_percent", exp_w.charge_percent, out_word.charge_percent);
        cmp_field("low_power_request", exp_w.low_power_request, out_word.low_power_request);
        cmp_field("save_percent", exp_w.save_percent, out_word.save_percent);
      end
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (final_run || calm_left > 0) begin
      pop <= 1'b1;
      if (calm_left > 0) calm_left--;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(5, 0) == 0) begin
        if ($urandom_range(3, 0) == 0) calm_left = $urandom_range(200, 50);
        else stall_left = $urandom_range(17, 1);
      end
    end
  end

  initial begin
    int r;
    int p;
    int g;
    in_word_t cw;
    logic [15:0] tv;
    errors = 0;
    final_run = 1'b0;
    sender_quiet = 1'b0;
    stall_left = 0;
    calm_left = 0;
    lvl = '{14'd7200, 13'd4200, 12'd3650, 12'd3500, 16'd5400};
    grp_count = 0;
    grp_peak = '0;
    held_mv = HELD_START_MV;
    rst <= 1'b1;
    push <= 1'b0;
    pop <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < PLAN_LEN; r++) begin
      cw = random_word();
      cw.on_charger = PLAN[r].on_chg;
      cw.charge_full = PLAN[r].chg_full;
      cw.stored_percent = PLAN[r].stored;
      cw.now_seconds = PLAN[r].now_s;
      cw.charge_start_seconds = PLAN[r].start_s;
      cw.charge_start_percent = PLAN[r].start_pct;
      put_group(PLAN[r].peak, cw, PLAN[r].typed, PLAN[r].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: set_levels(16'd1000, 16'd4101, 16'd3001, 16'd3000, 16'd1);
        1: set_levels(16'd16383, 16'd5000, 16'd3699, 16'd3698, 16'd65535);
        2: set_levels(16'd7200, 16'd4200, 16'd3650, 16'd3500, 16'd0);
        3: set_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        default: begin
          tv = 16'($urandom_range(3699, 3001));
          set_levels(16'($urandom_range(16383, 1000)), 16'($urandom_range(5000, 4101)),
                     tv, 16'($urandom_range(tv - 1, 3000)), 16'($urandom_range(65535, 1)));
        end
      endcase
      final_run = (p == NUM_PHASES - 1);
      for (g = 0; g < PHASE_GROUPS; g++) random_group();
    end

    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
